[sv/otrb_pkg.sv]
// shared types and constants for the oldest-timestamp reorder buffer
`timescale 1ns / 1ps

package otrb_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int TIME_W = 64;
  localparam int DESC_W = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [DESC_W-1:0] descriptor;
  } otrb_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] released_time;
    logic [DESC_W-1:0] released_descriptor;
  } otrb_out_t;

  // running oldest candidate handed from cell to cell
  typedef struct packed {
    logic              valid;
    idx_t              idx;
    logic [TIME_W-1:0] ts;
    logic [DESC_W-1:0] desc;
  } cand_t;

endpackage

[sv/oldest_timestamp_reorder_buffer.sv]
// top level: oldest-timestamp reorder buffer built from a chain of slot cells
// an item that does not fill the buffer to capacity leaves the block idle
// an item that triggers a release starts a sweep; its result is registered when the sweep ends
// (the oldest candidate ripples one cell per cycle through the DEPTH cells)
// without release busy stays low for the next item; with a release busy stays high until the sweep ends
// reset: synchronous active-low, clears valid marks and occupancy, capacity to 16
// the result strobe lasts one cycle and the receiver cannot stall it
`timescale 1ns / 1ps

module oldest_timestamp_reorder_buffer
  import otrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  otrb_in_t         in_data,
  output logic             out_valid,
  output otrb_out_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  // control state
  logic             state_r;
  logic             state_nxt;
  logic [OCC_W-1:0] sweep_cnt_r;
  logic [OCC_W-1:0] sweep_cnt_nxt;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  otrb_out_t        out_data_r;

  // cell row
  cand_t            chain [DEPTH+1];
  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] wr_vec;
  logic [DEPTH-1:0] clr_vec;

  logic             accept;
  logic             free_found;
  idx_t             free_idx;
  logic [OCC_W-1:0] occ_after_wr;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic             need_release;
  logic             sweep_done;
  logic             release_en;
  cand_t            best;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // lowest-numbered free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!valid_vec[k]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(k);
      end
    end
  end

  // capacity of zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign occ_after_wr = free_found ? (occ_r + OCC_W'(1)) : occ_r;
  assign need_release = (CMP_W'(occ_after_wr) >= eff_cap);

  // chain head carries no candidate; the tail holds the oldest valid entry
  assign chain[0] = '0;
  assign best     = chain[DEPTH];

  assign sweep_done = (state_r == ST_SWEEP) && (sweep_cnt_r == '0);
  assign release_en = sweep_done && best.valid;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      wr_vec[k]  = accept && free_found && (free_idx == IDX_W'(k));
      clr_vec[k] = release_en && (best.idx == IDX_W'(k));
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      otrb_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .slot_idx  (IDX_W'(g)),
        .wr_en     (wr_vec[g]),
        .wr_time   (in_data.arrival_time),
        .wr_desc   (in_data.descriptor),
        .clr_en    (clr_vec[g]),
        .cand_in   (chain[g]),
        .cand_out  (chain[g+1]),
        .valid_out (valid_vec[g])
      );
    end
  endgenerate

  // sequencer: after a write that reaches capacity, wait for the chain to settle
  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    occ_nxt       = occ_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          occ_nxt = occ_after_wr;
          if (need_release) begin
            state_nxt     = ST_SWEEP;
            sweep_cnt_nxt = OCC_W'(DEPTH);
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_cnt_r == '0) begin
          state_nxt = ST_IDLE;
          if (best.valid && (occ_r != '0)) begin
            occ_nxt = occ_r - OCC_W'(1);
          end
        end else begin
          sweep_cnt_nxt = sweep_cnt_r - OCC_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sweep_cnt_r <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= release_en;
    end
  end

  // capacity register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // result transaction payload
  always_ff @(posedge clk) begin
    if (release_en) begin
      out_data_r.released_time       <= best.ts;
      out_data_r.released_descriptor <= best.desc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupancy always matches the number of valid slots
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) == $countones(valid_vec))
    else $error("occupancy out of step with slot valid marks");

  // a result only follows the end of a sweep
  a_result_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(sweep_done))
    else $error("result without a finished sweep");

  // an accepted transaction that reaches capacity starts a sweep
  a_sweep_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && need_release) |=> (state_r == ST_SWEEP))
    else $error("no sweep after buffer reached capacity");

  // the released entry is cleared from its slot
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    release_en |=> ($countones(valid_vec) == $countones($past(valid_vec)) - 1))
    else $error("released slot not freed");

endmodule

[sv/otrb_cell.sv]
// one slot of the buffer plus one stage of the oldest-entry chain
`timescale 1ns / 1ps

module otrb_cell
  import otrb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  idx_t              slot_idx,
  input  logic              wr_en,
  input  logic [TIME_W-1:0] wr_time,
  input  logic [DESC_W-1:0] wr_desc,
  input  logic              clr_en,
  input  cand_t             cand_in,
  output cand_t             cand_out,
  output logic              valid_out
);

  logic              valid_r;
  logic [TIME_W-1:0] time_r;
  logic [DESC_W-1:0] desc_r;
  cand_t             cand_r;
  cand_t             cand_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end else if (clr_en) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_r <= wr_time;
      desc_r <= wr_desc;
    end
  end

  // strict compare: an earlier slot keeps the win on equal timestamps
  always_comb begin
    cand_nxt = cand_in;
    if (valid_r && (!cand_in.valid || (time_r < cand_in.ts))) begin
      cand_nxt.valid = 1'b1;
      cand_nxt.idx   = slot_idx;
      cand_nxt.ts    = time_r;
      cand_nxt.desc  = desc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_out  = cand_r;
  assign valid_out = valid_r;

endmodule

[tb/oldest_timestamp_reorder_buffer_test.sv]
// self-checking testbench for the oldest-timestamp reorder buffer
`timescale 1ns / 1ps

module oldest_timestamp_reorder_buffer_test;
  import otrb_pkg::*;

  // stop the random part once this many packets have gone in
  localparam int RANDOM_ITEMS = 2000;
  // margin long enough for a release to ripple through all DEPTH cells, so this covers
  // any transaction still in flight when the last expected release shows up
  localparam int SETTLE_CYCLES = DEPTH + 4;
  localparam int MAX_REPORTS = 10;
  localparam logic [TIME_W-1:0] ALL_ONES = '1;
  localparam logic [TIME_W-1:0] ALT_55 = 64'h5555_5555_5555_5555;
  localparam logic [TIME_W-1:0] ALT_AA = 64'hAAAA_AAAA_AAAA_AAAA;

  // one row of the directed table: either a capacity write or a packet
  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;
  // how a packet row is checked: by the predictor, not at all, or against a typed answer
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_e;

  typedef struct {
    row_kind_e        kind;
    logic [CAP_W-1:0] cap;
    otrb_in_t         pkt;
    row_check_e       check;
    otrb_out_t        want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  otrb_in_t         in_data = '0;
  logic             out_valid;
  otrb_out_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // shadow copy of the buffer contents used to predict releases
  logic              held_valid [DEPTH];
  logic [TIME_W-1:0] held_time [DEPTH];
  logic [DESC_W-1:0] held_desc [DEPTH];
  int                held_count;
  logic [CAP_W-1:0]  cap_reg;

  // releases still owed by the block, oldest first
  otrb_out_t release_q[$];
  stim_row_t stim_table[$];
  int        err_count = 0;
  int        burst_left = 0;

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  oldest_timestamp_reorder_buffer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // store the packet in the lowest free slot; once occupancy reaches the
  // effective capacity, pull out the smallest timestamp (lowest slot on ties,
  // the new packet included)
  function automatic bit predict_release(input otrb_in_t pkt, output otrb_out_t rel);
    int free_idx;
    int best;
    int eff_cap;
    rel = '0;
    free_idx = -1;
    best = -1;
    for (int k = 0; k < DEPTH; k++) begin
      if (!held_valid[k]) begin
        free_idx = k;
        break;
      end
    end
    if (free_idx >= 0) begin
      held_valid[free_idx] = 1'b1;
      held_time[free_idx] = pkt.arrival_time;
      held_desc[free_idx] = pkt.descriptor;
      held_count++;
    end
    // zero acts as one, anything above DEPTH acts as DEPTH
    if (cap_reg == 0) eff_cap = 1;
    else if (int'(cap_reg) > DEPTH) eff_cap = DEPTH;
    else eff_cap = int'(cap_reg);
    if (held_count < eff_cap) return 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      if (held_valid[k] && (best < 0 || held_time[k] < held_time[best])) best = k;
    end
    if (best < 0) return 1'b0;
    rel.released_time = held_time[best];
    rel.released_descriptor = held_desc[best];
    held_valid[best] = 1'b0;
    if (held_count > 0) held_count--;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%0t mismatch %s: expected %h actual %h", $realtime, what, want_v, got_v);
    end
  endtask

  // every strobed release is compared with the oldest owed one
  always @(posedge clk) begin
    otrb_out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (release_q.size() == 0) begin
        note_mismatch("unexpected release time", '0, out_data.released_time);
      end else begin
        want = release_q.pop_front();
        if (out_data.released_time !== want.released_time) begin
          note_mismatch("released_time", want.released_time, out_data.released_time);
        end
        if (out_data.released_descriptor !== want.released_descriptor) begin
          note_mismatch("released_descriptor", want.released_descriptor,
                        out_data.released_descriptor);
        end
      end
    end
  end

  // present one packet from a falling edge and hold it until start meets !busy;
  // returns at the following falling edge with start still high
  task automatic send_packet(input otrb_in_t pkt, input row_check_e check,
                             input otrb_out_t want);
    otrb_out_t rel;
    bit        fired;
    start = 1'b1;
    in_data = pkt;
    do @(posedge clk); while (busy !== 1'b0);
    fired = predict_release(pkt, rel);
    if (check == CHK_ONE) release_q.push_back(want);
    else if (check == CHK_MODEL && fired) release_q.push_back(rel);
    @(negedge clk);
  endtask

  // sender works in bursts; between bursts it usually drops start for a while
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 25)) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // pause until every owed release has arrived and the block has settled
  task automatic wait_drained();
    start = 1'b0;
    while (release_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    cap_reg = value;
  endtask

  task automatic add_cfg(input logic [CAP_W-1:0] value);
    stim_row_t row;
    row = '{kind: ROW_CFG, cap: value, pkt: '0, check: CHK_NONE, want: '0};
    stim_table.push_back(row);
  endtask

  task automatic add_item(input logic [TIME_W-1:0] t, input logic [DESC_W-1:0] d,
                          input row_check_e check, input logic [TIME_W-1:0] want_t,
                          input logic [DESC_W-1:0] want_d);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.cap = '0;
    row.pkt.arrival_time = t;
    row.pkt.descriptor = d;
    row.check = check;
    row.want.released_time = want_t;
    row.want.released_descriptor = want_d;
    stim_table.push_back(row);
  endtask

  // random packet: plenty of small timestamps so ties happen, plus the extremes
  function automatic otrb_in_t rand_packet();
    otrb_in_t pkt;
    case ($urandom_range(0, 9))
      0:       pkt.arrival_time = '0;
      1:       pkt.arrival_time = ALL_ONES;
      2, 3, 4: pkt.arrival_time = 64'($urandom_range(0, 7));
      5:       pkt.arrival_time = ALL_ONES - 64'($urandom_range(0, 7));
      default: pkt.arrival_time = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 7))
      0:       pkt.descriptor = '0;
      1:       pkt.descriptor = ALL_ONES;
      default: pkt.descriptor = {$urandom, $urandom};
    endcase
    return pkt;
  endfunction

  initial begin
    int unsigned phase_caps [5];
    int          items_sent;
    int          phase;
    int          phase_len;
    logic [TIME_W-1:0] fill_t;

    phase_caps = '{16, 0, 31, 1, 2};
    for (int k = 0; k < DEPTH; k++) begin
      held_valid[k] = 1'b0;
      held_time[k] = '0;
      held_desc[k] = '0;
    end
    held_count = 0;
    cap_reg = CAP_RESET;

    // capacity one releases each packet straight back
    add_cfg(5'd1);
    add_item('0, '0, CHK_ONE, '0, '0);
    add_item(ALL_ONES, ALL_ONES, CHK_ONE, ALL_ONES, ALL_ONES);
    // capacity zero behaves as one
    add_cfg(5'd0);
    add_item(ALT_55, ALT_AA, CHK_ONE, ALT_55, ALT_AA);
    add_item(ALT_AA, ALT_55, CHK_ONE, ALT_AA, ALT_55);
    // capacity two: older wins, ties go to the lower slot, new packet can win
    add_cfg(5'd2);
    add_item(64'd100, 64'd1, CHK_NONE, '0, '0);
    add_item(64'd50, 64'd2, CHK_ONE, 64'd50, 64'd2);
    add_item(64'd100, 64'd3, CHK_ONE, 64'd100, 64'd1);
    add_item(ALL_ONES, 64'd4, CHK_ONE, 64'd100, 64'd3);
    add_item('0, 64'd5, CHK_ONE, '0, 64'd5);
    // capacity above DEPTH saturates: fill every slot, then one release
    add_cfg(5'd31);
    for (int k = 0; k < DEPTH - 1; k++) begin
      fill_t = (64'd1 << (4 * k + 3)) | 64'(k);
      add_item(fill_t, ~fill_t, CHK_MODEL, '0, '0);
    end
    // lowering the capacity below the occupancy flushes nothing
    add_cfg(5'd3);
    add_item(64'd8, 64'd77, CHK_MODEL, '0, '0);

    // reset held from the start, released on a falling edge
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        set_capacity(stim_table[i].cap);
      end else begin
        pace_sender();
        send_packet(stim_table[i].pkt, stim_table[i].check, stim_table[i].want);
      end
    end

    // random phases, each under its own capacity; every capacity write
    // also makes the sender wait for the buffer to drain its owed releases
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase < 5) set_capacity(CAP_W'(phase_caps[phase]));
      else set_capacity(CAP_W'($urandom_range(0, 31)));
      phase_len = $urandom_range(80, 250);
      for (int n = 0; n < phase_len && items_sent < RANDOM_ITEMS; n++) begin
        pace_sender();
        send_packet(rand_packet(), CHK_MODEL, '0);
        items_sent++;
      end
      phase++;
    end

    wait_drained();
    if (err_count == 0 && release_q.size() == 0) begin
      $display("oldest_timestamp_reorder_buffer_test: clean");
    end else begin
      $display("oldest_timestamp_reorder_buffer_test: errors");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #20000000;
    $display("oldest_timestamp_reorder_buffer_test: errors");
    $finish;
  end

endmodule

[sim.f]
sv/otrb_pkg.sv
sv/otrb_cell.sv
sv/oldest_timestamp_reorder_buffer.sv
tb/oldest_timestamp_reorder_buffer_test.sv
